>>> hdl/wsd_pkg.sv
package wsd_pkg;

    // parse phase codes
    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_EXT16 = 3'd2;
    localparam logic [2:0] PH_EXT64 = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_EMPTY     = 2'd1;
    localparam logic [1:0] KIND_BAD_OP    = 2'd2;
    localparam logic [1:0] KIND_UNMASKED  = 2'd3;

    // accepted frame opcodes
    localparam logic [3:0] OP_CONT        = 4'h0;
    localparam logic [3:0] OP_TEXT        = 4'h1;
    localparam logic [3:0] OP_BIN         = 4'h2;
    localparam logic [3:0] OP_CLOSE       = 4'h8;
    localparam logic [3:0] OP_PING        = 4'h9;
    localparam logic [3:0] OP_PONG        = 4'hA;

    // opcodes and length markers
    localparam logic [3:0] OP_CONTROL_MIN = 4'h8;
    localparam logic [6:0] LEN_EXT16      = 7'd126;
    localparam logic [6:0] LEN_EXT64      = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] KEY_BYTES      = 4'd4;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic [3:0] message_opcode;
        logic       final_fragment;
        logic       frame_last;
    } t_result;

endpackage

>>> hdl/wsd_parser.sv
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_require_mask,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    logic [2:0]  r_phase,   n_phase;
    logic [3:0]  r_cnt,     n_cnt;
    logic        r_fin,     n_fin;
    logic [3:0]  r_cur_op,  n_cur_op;
    logic [3:0]  r_msg_op,  n_msg_op;
    logic        r_in_msg,  n_in_msg;
    logic        r_mask,    n_mask;
    logic [63:0] r_len,     n_len;
    logic [31:0] r_key,     n_key;
    logic [1:0]  r_kidx,    n_kidx;
    logic        r_halted,  n_halted;

    logic [3:0]  cnt_inc;
    logic [3:0]  ext_need;
    logic [7:0]  key_byte;
    t_result     res;

    assign cnt_inc  = r_cnt + 4'd1;
    assign ext_need = (r_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;

    always_comb begin
        case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_fin    = r_fin;
        n_cur_op = r_cur_op;
        n_msg_op = r_msg_op;
        n_in_msg = r_in_msg;
        n_mask   = r_mask;
        n_len    = r_len;
        n_key    = r_key;
        n_kidx   = r_kidx;
        n_halted = r_halted;
        res      = '0;

        if (!r_halted) begin
            case (r_phase)
                PH_HDR1: begin
                    n_mask = i_rx_byte[7];
                    n_key  = '0;
                    if (!i_rx_byte[7] && i_require_mask) begin
                        n_halted   = 1'b1;
                        res.valid  = 1'b1;
                        res.kind   = KIND_UNMASKED;
                        res.frame_last = 1'b1;
                    end else begin
                        n_cnt = '0;
                        n_len = '0;
                        if (i_rx_byte[6:0] == LEN_EXT16) begin
                            n_phase = PH_EXT16;
                        end else if (i_rx_byte[6:0] == LEN_EXT64) begin
                            n_phase = PH_EXT64;
                        end else begin
                            n_len = {57'd0, i_rx_byte[6:0]};
                            if (i_rx_byte[7]) begin
                                n_phase = PH_KEY;
                            end else begin
                                n_kidx = '0;
                                if (i_rx_byte[6:0] == 7'd0) begin
                                    n_phase        = PH_HDR0;
                                    res.valid      = 1'b1;
                                    res.kind       = KIND_EMPTY;
                                    res.frame_last = 1'b1;
                                end else begin
                                    n_phase = PH_DATA;
                                end
                            end
                        end
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    n_len = {r_len[55:0], i_rx_byte};
                    n_cnt = cnt_inc;
                    if (cnt_inc >= ext_need) begin
                        n_cnt = '0;
                        if (r_mask) begin
                            n_phase = PH_KEY;
                        end else begin
                            n_kidx = '0;
                            if (n_len == 64'd0) begin
                                n_phase        = PH_HDR0;
                                res.valid      = 1'b1;
                                res.kind       = KIND_EMPTY;
                                res.frame_last = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], i_rx_byte};
                    n_cnt = cnt_inc;
                    if (cnt_inc >= KEY_BYTES) begin
                        n_cnt  = '0;
                        n_kidx = '0;
                        if (r_len == 64'd0) begin
                            n_phase        = PH_HDR0;
                            res.valid      = 1'b1;
                            res.kind       = KIND_EMPTY;
                            res.frame_last = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_kidx = r_kidx + 2'd1;
                    n_len  = r_len - 64'd1;
                    res.valid        = 1'b1;
                    res.kind         = KIND_DATA;
                    res.payload_byte = i_rx_byte ^ key_byte;
                    res.frame_last   = (n_len == 64'd0);
                    if (n_len == 64'd0) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    // first header byte
                    n_fin    = i_rx_byte[7];
                    n_cur_op = i_rx_byte[3:0];
                    if (!(i_rx_byte[3:0] inside
                          {[OP_CONT:OP_BIN], OP_CLOSE, OP_PING, OP_PONG})) begin
                        n_halted       = 1'b1;
                        res.valid      = 1'b1;
                        res.kind       = KIND_BAD_OP;
                        res.frame_last = 1'b1;
                    end else begin
                        if (i_rx_byte[3:0] < OP_CONTROL_MIN) begin
                            if (i_rx_byte[3:0] != OP_CONT || !r_in_msg) begin
                                n_msg_op = i_rx_byte[3:0];
                            end
                            n_in_msg = !i_rx_byte[7];
                        end
                        n_phase = PH_HDR1;
                    end
                end
            endcase
        end

        // tags come from the frame state as updated by this word
        res.frame_opcode   = n_cur_op;
        res.message_opcode = (n_cur_op >= OP_CONTROL_MIN) ? n_cur_op : n_msg_op;
        res.final_fragment = n_fin;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_cnt    <= '0;
            r_fin    <= 1'b1;
            r_cur_op <= '0;
            r_msg_op <= '0;
            r_in_msg <= 1'b0;
            r_mask   <= 1'b0;
            r_len    <= '0;
            r_key    <= '0;
            r_kidx   <= '0;
            r_halted <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_fin    <= n_fin;
            r_cur_op <= n_cur_op;
            r_msg_op <= n_msg_op;
            r_in_msg <= n_in_msg;
            r_mask   <= n_mask;
            r_len    <= n_len;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
            r_halted <= n_halted;
        end
    end

endmodule

>>> hdl/websocket_frame_deframer_unit.sv
// channel   direction  signals                         contents
// s_axis    in         tvalid tready tdata[7:0]        raw received byte
// m_axis    out        tvalid tready tdata tuser tlast one parsed word per result
// cfg       in         i_cfg_valid o_cfg_ready data    require_mask bit
//
// one byte is taken per cycle unless s_axis stalls; header parsing, length handling
// and unmasking are done in one pass from the parse state to the output register.
// the result of an accepted byte is registered and shown on m_axis in the next cycle.
// synchronous active-low reset returns to the first header byte, require_mask 1.
// s_axis stalls only while a result sits in the output register and m_axis is
// not ready; after a fatal error the unit keeps taking bytes and drops them.
module websocket_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                        // [15:12] message_opcode, [16] final_fragment,
                                        // [23:17] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // frame_last
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // require_mask
);
    import wsd_pkg::*;

    logic    r_require_mask;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    take;

    // output register free or being drained this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_mask <= 1'b1;
        end else if (i_cfg_valid) begin
            r_require_mask <= i_cfg_data;
        end
    end

    wsd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_rx_byte      (s_axis_tdata),
        .i_require_mask (r_require_mask),
        .o_res          (res)
    );

    // output register, loaded only when the byte gives a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.final_fragment, r_out.message_opcode,
                            r_out.frame_opcode, r_out.payload_byte};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.frame_last;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import wsd_pkg::*;

    // opcodes the deframer accepts
    localparam logic [3:0] OP_TOP   = 4'hF;
    localparam logic [3:0] GOOD_OPS [6] = '{OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG};

    localparam int IDLE_PCT        = 24;
    localparam int PRESSURE_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASE_BYTES     = 190;
    localparam int DIR_ROWS        = 27;

    // how a frame length goes on the wire
    typedef enum int {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} t_len_form;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] fop;
        logic [3:0] mop;
        logic       fin;
        logic       last;
    } t_exp_word;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        t_exp_word  want;
    } t_stim;

    localparam t_exp_word NO_WORD    = '0;
    localparam t_exp_word EMPTY_TEXT = '{KIND_EMPTY, 8'h00, OP_TEXT, OP_TEXT, 1'b1, 1'b1};
    localparam t_exp_word EMPTY_PING = '{KIND_EMPTY, 8'h00, OP_PING, OP_PING, 1'b1, 1'b1};

    // directed frames: empty text, fragmented binary, ping inside the message,
    // continuation that closes the message
    localparam t_stim DIR_TABLE [DIR_ROWS] = '{
        '{8'h81, 1'b0, NO_WORD}, '{8'h80, 1'b0, NO_WORD},
        '{8'h12, 1'b0, NO_WORD}, '{8'h34, 1'b0, NO_WORD},
        '{8'h56, 1'b0, NO_WORD}, '{8'h78, 1'b1, EMPTY_TEXT},
        '{8'h02, 1'b0, NO_WORD}, '{8'h82, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'hA5, 1'b0, NO_WORD}, '{8'h5A, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
        '{8'h89, 1'b0, NO_WORD}, '{8'h80, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b1, EMPTY_PING},
        '{8'h80, 1'b0, NO_WORD}, '{8'h81, 1'b0, NO_WORD},
        '{8'hC3, 1'b0, NO_WORD}, '{8'h3C, 1'b0, NO_WORD},
        '{8'h96, 1'b0, NO_WORD}, '{8'h69, 1'b0, NO_WORD},
        '{8'h5A, 1'b0, NO_WORD}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;   // [7:0] payload_byte, [11:8] frame_opcode,
                                 // [15:12] message_opcode, [16] final_fragment
    logic [1:0]  m_axis_tuser;   // [1:0] kind
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    // bytes waiting to go out and the words they are predicted to produce
    t_stim     byte_feed [$];
    t_exp_word expected_words [$];

    // shadow of the parser state
    logic [2:0]  ph        = PH_HDR0;
    logic [3:0]  hdr_cnt   = '0;
    logic        fin_q     = 1'b1;
    logic [3:0]  op_q      = '0;
    logic [3:0]  msg_op_q  = '0;
    logic        in_msg    = 1'b0;
    logic        mask_q    = 1'b0;
    logic [63:0] rem_len   = '0;
    logic [31:0] key_q     = '0;
    logic [1:0]  key_idx   = '0;
    logic        dead      = 1'b0;
    logic        req_mask  = 1'b1;

    bit idle_on     = 1'b1;
    bit hold_off    = 1'b0;
    bit pressure_go = 1'b0;
    int fail_count  = 0;
    int bytes_in    = 0;
    int frames_sent = 0;
    int cfg_writes  = 0;
    int kind_count [4] = '{0, 0, 0, 0};

    websocket_frame_deframer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------

    // control frames report their own opcode as the message opcode
    function automatic t_exp_word make_word(logic [1:0] k, logic [7:0] d, logic last);
        t_exp_word w;
        w.kind = k;
        w.data = d;
        w.fop  = op_q;
        w.mop  = (op_q >= OP_CONTROL_MIN) ? op_q : msg_op_q;
        w.fin  = fin_q;
        w.last = last;
        return w;
    endfunction

    // header done: payload follows, or an empty frame closes right here
    function automatic void start_payload(output bit got, output t_exp_word w);
        got = 1'b0;
        w = '0;
        key_idx = '0;
        if (rem_len == 64'd0) begin
            ph = PH_HDR0;
            got = 1'b1;
            w = make_word(KIND_EMPTY, 8'h00, 1'b1);
        end else begin
            ph = PH_DATA;
        end
    endfunction

    function automatic void length_done(output bit got, output t_exp_word w);
        got = 1'b0;
        w = '0;
        hdr_cnt = '0;
        if (mask_q)
            ph = PH_KEY;
        else
            start_payload(got, w);
    endfunction

    function automatic void deframe_step(input logic [7:0] b, output bit got,
                                         output t_exp_word w);
        logic [7:0] kb;
        logic       last;
        got = 1'b0;
        w = '0;
        if (dead)
            return;
        case (ph)
            PH_HDR1: begin
                mask_q = b[7];
                key_q = '0;
                if (!mask_q && req_mask) begin
                    dead = 1'b1;
                    got = 1'b1;
                    w = make_word(KIND_UNMASKED, 8'h00, 1'b1);
                end else begin
                    hdr_cnt = '0;
                    rem_len = '0;
                    if (b[6:0] == LEN_EXT16) begin
                        ph = PH_EXT16;
                    end else if (b[6:0] == LEN_EXT64) begin
                        ph = PH_EXT64;
                    end else begin
                        rem_len = 64'(b[6:0]);
                        length_done(got, w);
                    end
                end
            end
            PH_EXT16, PH_EXT64: begin
                rem_len = {rem_len[55:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt >= ((ph == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
                    length_done(got, w);
            end
            PH_KEY: begin
                key_q = {key_q[23:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt >= KEY_BYTES) begin
                    hdr_cnt = '0;
                    start_payload(got, w);
                end
            end
            PH_DATA: begin
                // key byte 0 is the first one received, so it sits on top
                kb = key_q[8 * (3 - key_idx) +: 8];
                key_idx = key_idx + 2'd1;
                rem_len = rem_len - 64'd1;
                last = (rem_len == 64'd0);
                if (last)
                    ph = PH_HDR0;
                got = 1'b1;
                w = make_word(KIND_DATA, b ^ kb, last);
            end
            default: begin
                fin_q = b[7];
                op_q = b[3:0];
                if (!(op_q inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG})) begin
                    dead = 1'b1;
                    got = 1'b1;
                    w = make_word(KIND_BAD_OP, 8'h00, 1'b1);
                end else begin
                    // data frames track the message, control frames leave it alone
                    if (op_q < OP_CONTROL_MIN) begin
                        if (op_q != OP_CONT || !in_msg)
                            msg_op_q = op_q;
                        in_msg = !fin_q;
                    end
                    ph = PH_HDR1;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void feed_stim(t_stim it);
        byte_feed.insert(byte_feed.size(), it);
    endfunction

    function automatic void expect_word(t_exp_word w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        t_stim it;
        it = '0;
        it.b = b;
        feed_stim(it);
    endfunction

    // one well-formed frame with random content; unmasked only when allowed
    function automatic void queue_frame(bit plain_ok);
        logic [3:0]  op;
        logic        fin;
        logic        masked;
        logic [63:0] len;
        logic [31:0] key;
        t_len_form   form;
        int          pick;
        op = GOOD_OPS[$urandom_range(0, 5)];
        fin = 1'($urandom);
        masked = plain_ok ? ($urandom_range(0, 3) != 0) : 1'b1;
        pick = $urandom_range(0, 99);
        form = LEN_SHORT;
        if (pick < 4) begin
            len = 64'd125;
        end else if (pick < 10) begin
            len = 64'd0;
            form = t_len_form'($urandom_range(0, 2));
        end else if (pick < 70) begin
            len = 64'($urandom_range(1, 16));
        end else if (pick < 84) begin
            len = 64'($urandom_range(1, 40));
            form = LEN_WIDE16;
        end else if (pick < 97) begin
            len = 64'($urandom_range(1, 40));
            form = LEN_WIDE64;
        end else begin
            len = 64'($urandom_range(126, 260));
            form = LEN_WIDE16;
        end
        // reserved bits are random, the parser does not look at them
        push_byte({fin, 3'($urandom), op});
        case (form)
            LEN_SHORT: push_byte({masked, len[6:0]});
            LEN_WIDE16: begin
                push_byte({masked, LEN_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default: begin
                push_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    push_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked) begin
            key = $urandom;
            for (int i = 3; i >= 0; i--)
                push_byte(key[8 * i +: 8]);
        end
        for (longint i = 0; i < longint'(len); i++)
            push_byte(8'($urandom));
        frames_sent++;
    endfunction

    // all bytes taken, all words seen, then room for a trailing header byte
    task automatic wait_drained();
        while (byte_feed.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_require_mask(input logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        req_mask = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic mask_setting, input bit squeeze);
        int queued;
        write_require_mask(mask_setting);
        queued = byte_feed.size();
        while (byte_feed.size() - queued < PHASE_BYTES)
            queue_frame(!mask_setting);
        // stall the output while the input keeps offering, so the unit backs up
        if (squeeze)
            pressure_go = 1'b1;
        wait_drained();
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stream in: one byte per handshake, next byte set up at the falling edge
    // ------------------------------------------------------------------
    initial begin
        t_stim     cur;
        bit        taken;
        bit        got;
        t_exp_word w;
        cur = '0;
        forever begin
            @(posedge i_clk);
            taken = s_axis_tvalid && s_axis_tready;
            if (taken) begin
                deframe_step(cur.b, got, w);
                bytes_in++;
                // typed rows carry their own expectation, the rest use the prediction
                if (cur.typed)
                    expect_word(cur.want);
                else if (got)
                    expect_word(w);
            end
            @(negedge i_clk);
            if (taken || !s_axis_tvalid) begin
                if (byte_feed.size() != 0 &&
                    !(idle_on && $urandom_range(0, 99) < IDLE_PCT)) begin
                    cur = byte_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= cur.b;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // stream out: ready drops at random, and for a long stretch on request
    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= !hold_off && !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // output hold-off, counted here so the driver keeps running meanwhile
    initial begin
        wait (pressure_go);
        hold_off = 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        t_exp_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("word with no expectation: tuser %0h tdata %h tlast %0b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                kind_count[want.kind]++;
                check_field("kind", 8'(want.kind), 8'(m_axis_tuser));
                check_field("payload_byte", want.data, m_axis_tdata[7:0]);
                check_field("frame_opcode", 8'(want.fop), 8'(m_axis_tdata[11:8]));
                check_field("message_opcode", 8'(want.mop), 8'(m_axis_tdata[15:12]));
                check_field("final_fragment", 8'(want.fin), 8'(m_axis_tdata[16]));
                check_field("frame_last", 8'(want.last), 8'(m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [3:0] bad_op;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under the reset value of require_mask
        foreach (DIR_TABLE[i])
            feed_stim(DIR_TABLE[i]);
        wait_drained();

        // random frames, alternating the mask requirement
        run_phase(1'b0, 1'b1);
        idle_on = 1'b0;
        run_phase(1'b1, 1'b0);
        idle_on = 1'b1;
        run_phase(1'b0, 1'b0);
        run_phase(1'b1, 1'b0);

        // one fatal error ends the stream, the unit stays silent afterward
        if ($urandom_range(0, 1)) begin
            push_byte({1'($urandom), 3'($urandom), GOOD_OPS[$urandom_range(0, 5)]});
            push_byte({1'b0, 7'($urandom)});
        end else begin
            bad_op = $urandom_range(0, 1) ? 4'($urandom_range(OP_BIN + 1, OP_CLOSE - 1))
                                          : 4'($urandom_range(OP_PONG + 1, OP_TOP));
            push_byte({1'($urandom), 3'($urandom), bad_op});
        end
        repeat (8) push_byte(8'($urandom));
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("run: %0d bytes, %0d random frames, %0d require_mask writes, %0d-cycle stall",
                 bytes_in, frames_sent, cfg_writes, PRESSURE_CYCLES);
        $display("words: %0d payload, %0d empty frame, %0d bad opcode, %0d unmasked",
                 kind_count[KIND_DATA], kind_count[KIND_EMPTY],
                 kind_count[KIND_BAD_OP], kind_count[KIND_UNMASKED]);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("tb passed");
        end else begin
            if (expected_words.size() != 0)
                $error("%0d expected words never arrived", expected_words.size());
            $display("tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("tb failed");
        $finish;
    end

endmodule
